>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, widths and the microcode program of the rational arithmetic
// unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 31;
    localparam int CMD_W         = 3;
    localparam int EXT_W         = (MAG_W > NUM_W) ? MAG_W : NUM_W;
    localparam int K_W           = $clog2(MAG_W);
    localparam int CNT_W         = $clog2(MAG_W);
    localparam int UPC_W         = 4;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]                cmd;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_equal;
        logic                    status;
    } t_res;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_A,
        OP_MUL_D,
        OP_MUL_B,
        OP_ADD,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_FIN,
        OP_DIVX_INIT,
        OP_DIV_STEP,
        OP_DIVX_DONE,
        OP_DIVY_DONE,
        OP_ZERO,
        OP_EMIT,
        OP_EMIT_SPECIAL
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_SPECIAL,
        C_NOT_ADDSUB,
        C_X_ZERO,
        C_GCD_RUN,
        C_DIV_RUN,
        C_G_ONE,
        C_END
    } t_cond;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Datapath flags tested by the sequencer's conditional jumps
    typedef struct packed {
        logic special;
        logic addsub;
        logic x_zero;
        logic gcd_run;
        logic div_run;
        logic g_one;
    } t_dp_flags;

    localparam t_upc UP_START    = 4'd0;
    localparam t_upc UP_GCD_INIT = 4'd5;
    localparam t_upc UP_GCD_LOOP = 4'd6;
    localparam t_upc UP_DIVX     = 4'd9;
    localparam t_upc UP_DIVY     = 4'd11;
    localparam t_upc UP_EMIT     = 4'd13;
    localparam t_upc UP_ZERO     = 4'd14;
    localparam t_upc UP_SPECIAL  = 4'd15;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_END, target: UP_START};
        case (pc)
            4'd0:  w = '{op: OP_NOP,          cond: C_SPECIAL,    target: UP_SPECIAL};
            4'd1:  w = '{op: OP_MUL_A,        cond: C_NEXT,       target: UP_START};
            4'd2:  w = '{op: OP_MUL_D,        cond: C_NOT_ADDSUB, target: UP_GCD_INIT};
            4'd3:  w = '{op: OP_MUL_B,        cond: C_NEXT,       target: UP_START};
            4'd4:  w = '{op: OP_ADD,          cond: C_NEXT,       target: UP_START};
            4'd5:  w = '{op: OP_GCD_INIT,     cond: C_X_ZERO,     target: UP_ZERO};
            4'd6:  w = '{op: OP_GCD_STEP,     cond: C_GCD_RUN,    target: UP_GCD_LOOP};
            4'd7:  w = '{op: OP_GCD_FIN,      cond: C_NEXT,       target: UP_START};
            4'd8:  w = '{op: OP_DIVX_INIT,    cond: C_G_ONE,      target: UP_EMIT};
            4'd9:  w = '{op: OP_DIV_STEP,     cond: C_DIV_RUN,    target: UP_DIVX};
            4'd10: w = '{op: OP_DIVX_DONE,    cond: C_NEXT,       target: UP_START};
            4'd11: w = '{op: OP_DIV_STEP,     cond: C_DIV_RUN,    target: UP_DIVY};
            4'd12: w = '{op: OP_DIVY_DONE,    cond: C_NEXT,       target: UP_START};
            4'd13: w = '{op: OP_EMIT,         cond: C_END,        target: UP_START};
            4'd14: w = '{op: OP_ZERO,         cond: C_JUMP,       target: UP_EMIT};
            4'd15: w = '{op: OP_EMIT_SPECIAL, cond: C_END,        target: UP_START};
            default: w = '{op: OP_NOP,        cond: C_END,        target: UP_START};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Working registers, shared multiplier, binary GCD and restoring divider,
// driven one operation per cycle by the microcode sequencer.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic           i_clk,
    input  rau_pkg::t_req  i_req,
    input  rau_pkg::t_op   i_op,
    output rau_pkg::t_dp_flags o_flags,
    output rau_pkg::t_res  o_res
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0]     an_mag, ad_mag, bn_mag, bd_mag;
    logic             an_neg, ad_neg, bn_neg, bd_neg;
    logic [W-1:0]     m1, m2;
    logic             m_neg;
    logic [MAG_W-1:0] prod;
    logic             prod_neg;

    logic [MAG_W-1:0] r_x, n_x, r_y, n_y, r_p, n_p;
    logic             r_xneg, n_xneg, r_yneg, n_yneg, r_pneg, n_pneg;
    logic [MAG_W-1:0] r_u, n_u, r_v, n_v, r_g, n_g;
    logic [K_W-1:0]   r_k, n_k;
    logic [MAG_W-1:0] r_q, n_q, r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [MAG_W:0]   trial;
    logic             trial_ge;
    logic             cmd_valid;
    logic             res_neg;
    logic [EXT_W-1:0] ext_num, sgn_num, ext_den;

    assign an_neg = i_req.a_num[W-1];
    assign ad_neg = i_req.a_den[W-1];
    assign bn_neg = i_req.b_num[W-1];
    assign bd_neg = i_req.b_den[W-1];
    assign an_mag = an_neg ? (~i_req.a_num + 1'b1) : i_req.a_num;
    assign ad_mag = ad_neg ? (~i_req.a_den + 1'b1) : i_req.a_den;
    assign bn_mag = bn_neg ? (~i_req.b_num + 1'b1) : i_req.b_num;
    assign bd_mag = bd_neg ? (~i_req.b_den + 1'b1) : i_req.b_den;

    // Operand select for the one shared multiplier
    always_comb begin
        m1    = an_mag;
        m2    = bd_mag;
        m_neg = an_neg ^ bd_neg;
        case (i_op)
            OP_MUL_A: begin
                m1 = an_mag;
                if (i_req.cmd == CMD_MUL) begin
                    m2    = bn_mag;
                    m_neg = an_neg ^ bn_neg;
                end else begin
                    m2    = bd_mag;
                    m_neg = an_neg ^ bd_neg;
                end
            end
            OP_MUL_D: begin
                m1 = ad_mag;
                if (i_req.cmd == CMD_DIV) begin
                    m2    = bn_mag;
                    m_neg = ad_neg ^ bn_neg;
                end else begin
                    m2    = bd_mag;
                    m_neg = ad_neg ^ bd_neg;
                end
            end
            OP_MUL_B: begin
                m1    = bn_mag;
                m2    = ad_mag;
                m_neg = bn_neg ^ ad_neg ^ (i_req.cmd == CMD_SUB);
            end
            default: begin
                m1    = an_mag;
                m2    = bd_mag;
                m_neg = an_neg ^ bd_neg;
            end
        endcase
    end

    assign prod     = m1 * m2;
    assign prod_neg = (prod != '0) && m_neg;

    assign trial    = {r_rem, r_q[MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, r_g});

    always_comb begin
        n_x    = r_x;
        n_xneg = r_xneg;
        n_y    = r_y;
        n_yneg = r_yneg;
        n_p    = r_p;
        n_pneg = r_pneg;
        n_u    = r_u;
        n_v    = r_v;
        n_k    = r_k;
        n_g    = r_g;
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        case (i_op)
            OP_MUL_A: begin
                n_x    = prod;
                n_xneg = prod_neg;
            end
            OP_MUL_D: begin
                n_y    = prod;
                n_yneg = prod_neg;
            end
            OP_MUL_B: begin
                n_p    = prod;
                n_pneg = prod_neg;
            end
            OP_ADD: begin
                if (r_xneg == r_pneg) begin
                    n_x    = r_x + r_p;
                    n_xneg = r_xneg;
                end else if (r_x >= r_p) begin
                    n_x    = r_x - r_p;
                    n_xneg = r_xneg;
                end else begin
                    n_x    = r_p - r_x;
                    n_xneg = r_pneg;
                end
                if (n_x == '0) begin
                    n_xneg = 1'b0;
                end
            end
            OP_GCD_INIT: begin
                n_u = r_x;
                n_v = r_y;
                n_k = '0;
            end
            OP_GCD_STEP: begin
                // hold once either side reaches zero
                if (r_u != '0 && r_v != '0) begin
                    if (!r_u[0] && !r_v[0]) begin
                        n_u = r_u >> 1;
                        n_v = r_v >> 1;
                        n_k = r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        n_u = r_u >> 1;
                    end else if (!r_v[0]) begin
                        n_v = r_v >> 1;
                    end else if (r_u >= r_v) begin
                        n_u = r_u - r_v;
                    end else begin
                        n_v = r_v - r_u;
                    end
                end
            end
            OP_GCD_FIN: begin
                n_g = (r_u | r_v) << r_k;
            end
            OP_DIVX_INIT: begin
                n_q   = r_x;
                n_rem = '0;
                n_cnt = '0;
            end
            OP_DIV_STEP: begin
                n_q = {r_q[MAG_W-2:0], trial_ge};
                if (trial_ge) begin
                    n_rem = MAG_W'(trial - {1'b0, r_g});
                end else begin
                    n_rem = trial[MAG_W-1:0];
                end
                n_cnt = r_cnt + 1'b1;
            end
            OP_DIVX_DONE: begin
                n_x   = r_q;
                n_q   = r_y;
                n_rem = '0;
                n_cnt = '0;
            end
            OP_DIVY_DONE: begin
                n_y = r_q;
            end
            OP_ZERO: begin
                n_x    = '0;
                n_xneg = 1'b0;
                n_y    = MAG_W'(1);
                n_yneg = 1'b0;
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_xneg <= n_xneg;
        r_y    <= n_y;
        r_yneg <= n_yneg;
        r_p    <= n_p;
        r_pneg <= n_pneg;
        r_u    <= n_u;
        r_v    <= n_v;
        r_k    <= n_k;
        r_g    <= n_g;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
    end

    assign cmd_valid = (i_req.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV});

    assign o_flags.special = !cmd_valid || (i_req.a_den == '0) || (i_req.b_den == '0) ||
                             ((i_req.cmd == CMD_DIV) && (i_req.b_num == '0));
    assign o_flags.addsub  = (i_req.cmd == CMD_ADD) || (i_req.cmd == CMD_SUB);
    assign o_flags.x_zero  = (r_x == '0);
    assign o_flags.gcd_run = (r_u != '0) && (r_v != '0);
    assign o_flags.div_run = (r_cnt != CNT_W'(MAG_W - 1));
    assign o_flags.g_one   = (r_g == MAG_W'(1));

    // Sign on the numerator, positive denominator
    assign res_neg = (r_x != '0) && (r_xneg != r_yneg);
    assign ext_num = EXT_W'(r_x);
    assign sgn_num = res_neg ? (~ext_num + 1'b1) : ext_num;
    assign ext_den = EXT_W'(r_y);

    always_comb begin
        if (i_op == OP_EMIT_SPECIAL) begin
            o_res.res_num  = '0;
            o_res.res_den  = '0;
            o_res.is_equal = (i_req.cmd == CMD_CMP) && (i_req.a_num == i_req.b_num) &&
                             (i_req.a_den == i_req.b_den);
            o_res.status   = (i_req.cmd != CMD_CMP);
        end else begin
            o_res.res_num  = sgn_num[NUM_W-1:0];
            o_res.res_den  = ext_den[DEN_W-1:0];
            o_res.is_equal = 1'b0;
            o_res.status   = 1'b0;
        end
    end

endmodule

>>> rtl/core/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Add, subtract, multiply, divide or compare two signed fractions; arithmetic
// results are reduced by their greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_req and raise i_start; the request is taken on a rising edge with
//   i_start high and o_busy low. o_busy stays high while the request is
//   worked on. The result appears on o_res for exactly one cycle with o_done
//   high, in the first cycle with o_busy low; a new request may be taken in
//   that same cycle. The receiver cannot stall, so o_res must be captured then.
//   Compare, errors and unused commands go straight to the result. Arithmetic
//   runs the control steps and multiplies, then the binary GCD loop (one step
//   per cycle) and two restoring divisions by the GCD; a zero numerator skips
//   the GCD and the divisions, and the divisions are skipped when the GCD is
//   one. The GCD loop and the one-bit-per-cycle divider dominate the run time.
//   Reset (synchronous, active low) drops any request in flight and clears
//   o_busy and o_done.
// ----------------------------------------------------------------------------
module rational_arith_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  rau_pkg::t_req i_req,
    output logic          o_done,
    output rau_pkg::t_res o_res
);
    import rau_pkg::*;

    logic      r_run, n_run;
    t_upc      r_pc, n_pc;
    t_req      r_req;
    t_res      r_res, dp_res;
    logic      r_done, n_done;
    t_uword    uw;
    t_op       op;
    t_dp_flags flags;
    logic      take;
    logic      accept;

    assign accept = i_start && !r_run;
    assign uw     = ucode(r_pc);
    assign op     = r_run ? uw.op : OP_NOP;

    rau_datapath u_dp (
        .i_clk   (i_clk),
        .i_req   (r_req),
        .i_op    (op),
        .o_flags (flags),
        .o_res   (dp_res)
    );

    always_comb begin
        case (uw.cond)
            C_NEXT:       take = 1'b0;
            C_JUMP:       take = 1'b1;
            C_SPECIAL:    take = flags.special;
            C_NOT_ADDSUB: take = !flags.addsub;
            C_X_ZERO:     take = flags.x_zero;
            C_GCD_RUN:    take = flags.gcd_run;
            C_DIV_RUN:    take = flags.div_run;
            C_G_ONE:      take = flags.g_one;
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        n_run  = r_run;
        n_pc   = r_pc;
        n_done = 1'b0;
        if (r_run) begin
            n_pc = take ? uw.target : r_pc + 1'b1;
            if (uw.cond == C_END) begin
                n_run = 1'b0;
            end
            if (uw.op == OP_EMIT || uw.op == OP_EMIT_SPECIAL) begin
                n_done = 1'b1;
            end
        end else if (accept) begin
            n_run = 1'b1;
            n_pc  = UP_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pc   <= UP_START;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_pc   <= n_pc;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (n_done) begin
            r_res <= dp_res;
        end
    end

    assign o_busy = r_run;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the request/result sequencing of the unit.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input rau_pkg::t_res o_res
);
    import rau_pkg::*;

    // A taken request keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but unit not busy");

    // Busy ends only with a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status) |-> (o_res.res_num == '0 && o_res.res_den == '0))
        else $error("error result with non-zero fraction");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

>>> test/rau_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_result_checker
// Watches the request and result channels of the rational arithmetic unit,
// works out the reduced fraction that each accepted request should give and
// compares every result with the oldest one still open.
// ----------------------------------------------------------------------------
module rau_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  rau_pkg::t_req i_req,
    input  logic          i_done,
    input  rau_pkg::t_res i_res,
    output int            o_fail_count,
    output int            o_open_count
);
    import rau_pkg::*;

    t_res open_results[$];
    t_res want;
    int   fail_tally = 0;
    int   open_tally = 0;

    assign o_fail_count = fail_tally;
    assign o_open_count = open_tally;

    // Cross-multiply or multiply the fields, reduce by Euclid's GCD and keep
    // the sign on the numerator.
    function automatic t_res rational_result(input t_req r);
        longint an, ad, bn, bd;
        longint num, den, x, y, t;
        logic   neg;
        t_res   res;
        res = '0;
        an  = longint'(r.a_num);
        ad  = longint'(r.a_den);
        bn  = longint'(r.b_num);
        bd  = longint'(r.b_den);
        if (r.cmd == CMD_CMP) begin
            res.is_equal = (r.a_num == r.b_num) && (r.a_den == r.b_den);
            return res;
        end
        if (r.cmd > CMD_CMP || ad == 0 || bd == 0 || (r.cmd == CMD_DIV && bn == 0)) begin
            res.status = 1'b1;
            return res;
        end
        case (r.cmd)
            CMD_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            CMD_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            CMD_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        neg = (num != 0) && ((num < 0) != (den < 0));
        x   = (num < 0) ? -num : num;
        y   = (den < 0) ? -den : den;
        // a zero numerator leaves the GCD at |den|, so the result becomes 0/1
        num = x;
        den = y;
        while (den != 0) begin
            t   = num % den;
            num = den;
            den = t;
        end
        x = x / num;
        y = y / num;
        res.res_num = NUM_W'(neg ? -x : x);
        res.res_den = DEN_W'(y);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // retire the result first: a new request may be taken on the same edge
            if (i_done) begin
                if (open_results.size() == 0) begin
                    $display("%0t: result with no request open: expected none, %s",
                             $time, "got:");
                    $display("    num=%0d den=%0d eq=%0b st=%0b",
                             i_res.res_num, i_res.res_den, i_res.is_equal, i_res.status);
                    fail_tally <= fail_tally + 1;
                end else begin
                    want = open_results.pop_front();
                    if (i_res.res_num !== want.res_num || i_res.res_den !== want.res_den ||
                        i_res.is_equal !== want.is_equal || i_res.status !== want.status) begin
                        $display("%0t: mismatch: expected num=%0d den=%0d eq=%0b st=%0b,",
                                 $time, want.res_num, want.res_den, want.is_equal,
                                 want.status);
                        $display("    got num=%0d den=%0d eq=%0b st=%0b",
                                 i_res.res_num, i_res.res_den, i_res.is_equal, i_res.status);
                        fail_tally <= fail_tally + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                open_results.push_back(rational_result(i_req));
            end
            open_tally <= open_results.size();
        end
    end

endmodule

>>> test/tb_rational_arith_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit
// Drives directed and random fraction requests into the rational arithmetic
// unit in bursts with random gaps; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1300;

    typedef logic signed [OPERAND_WIDTH-1:0] t_operand;

    localparam t_operand OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
    localparam t_operand OP_MAX = ~OP_MIN;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic o_done;
    t_req i_req;
    t_res o_res;
    int   fail_count;
    int   open_count;
    int   quiet_cycles = 0;
    int   burst_left;

    rational_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    rau_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    function automatic t_req fraction_pair(input logic [CMD_W-1:0] cmd, input int an,
                                           input int ad, input int bn, input int bd);
        t_req r;
        r.cmd   = cmd;
        r.a_num = t_operand'(an);
        r.a_den = t_operand'(ad);
        r.b_num = t_operand'(bn);
        r.b_den = t_operand'(bd);
        return r;
    endfunction

    function automatic t_operand random_operand();
        int pick;
        pick = $urandom_range(19, 0);
        if (pick < 12) begin
            return t_operand'($urandom);
        end else if (pick < 16) begin
            return t_operand'(int'($urandom_range(8, 0)) - 4);
        end else if (pick < 19) begin
            case ($urandom_range(4, 0))
                0:       return OP_MIN;
                1:       return OP_MAX;
                2:       return t_operand'(-1);
                3:       return t_operand'(1);
                default: return '0;
            endcase
        end
        return '0;
    endfunction

    function automatic t_req random_request();
        t_req r;
        if ($urandom_range(19, 0) == 0) begin
            r.cmd = CMD_W'($urandom_range(2**CMD_W - 1, CMD_CMP + 1));
        end else begin
            r.cmd = CMD_W'($urandom_range(CMD_CMP, CMD_ADD));
        end
        r.a_num = random_operand();
        r.a_den = random_operand();
        r.b_num = random_operand();
        r.b_den = random_operand();
        // make compares hit equality often
        if (r.cmd == CMD_CMP) begin
            case ($urandom_range(3, 0))
                0: begin
                    r.b_num = r.a_num;
                    r.b_den = r.a_den;
                end
                1:       r.b_num = r.a_num;
                2:       r.b_den = r.a_den;
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic drive_request(input t_req r);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic hold_off(input int cycles);
        for (int k = 0; k < cycles; k++) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_req   <= random_request();
        end
    endtask

    task automatic issue(input t_req r);
        int gap;
        drive_request(r);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 0) : $urandom_range(8, 0);
            hold_off(gap);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        burst_left = $urandom_range(30, 1);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(fraction_pair(CMD_ADD, 1, 2, 1, 3));
        issue(fraction_pair(CMD_SUB, 3, 4, 3, 4));
        issue(fraction_pair(CMD_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN));
        issue(fraction_pair(CMD_DIV, OP_MAX, OP_MIN, OP_MIN, OP_MAX));
        issue(fraction_pair(CMD_ADD, OP_MIN, OP_MAX, OP_MIN, OP_MAX));
        issue(fraction_pair(CMD_SUB, OP_MAX, OP_MIN, OP_MIN, OP_MAX));
        issue(fraction_pair(CMD_MUL, -1, -1, 1, 1));
        issue(fraction_pair(CMD_DIV, 0, 5, 3, 7));
        // division by a zero fraction
        issue(fraction_pair(CMD_DIV, 5, 7, 0, 3));
        // zero denominators on either side
        issue(fraction_pair(CMD_ADD, 1, 0, 1, 1));
        issue(fraction_pair(CMD_SUB, 1, 1, 1, 0));
        issue(fraction_pair(CMD_MUL, 0, 0, 0, 0));
        // compare takes the raw fields and makes no denominator check
        issue(fraction_pair(CMD_CMP, 5, -7, 5, -7));
        issue(fraction_pair(CMD_CMP, 5, 7, 5, -7));
        issue(fraction_pair(CMD_CMP, 0, 0, 0, 0));
        issue(fraction_pair(CMD_CMP, OP_MIN, OP_MAX, OP_MIN, OP_MAX));
        issue(fraction_pair(CMD_CMP, 2, 4, 1, 2));
        for (int c = CMD_CMP + 1; c < 2**CMD_W; c++) begin
            issue(fraction_pair(CMD_W'(c), 1, 1, 1, 1));
        end
        issue(fraction_pair(CMD_ADD, 6, 4, 0, 9));
        issue(fraction_pair(CMD_MUL, OP_MAX, 1, OP_MAX, 1));
        issue(fraction_pair(CMD_DIV, -1, OP_MAX, OP_MAX, -1));
        issue(fraction_pair(CMD_ADD, -1, -1, -1, -1));

        repeat (RANDOM_ITEMS) begin
            issue(random_request());
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        while (open_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
